// ===== src/integer_literal_parser_assert.svh =====
// Assertion macros shared by the integer literal parser modules.
// Needs clk and rst in the scope of each use.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ILP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ilp_pkg.sv =====
// Shared types and constants of the integer literal parser.
// No dependencies.
package ilp_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 64;
  localparam int DIGIT_W = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // word index of the configuration registers
  localparam logic [0:0] REG_LONG_IS_64_BIT = 1'b0;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_UP_U  = 8'h55;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
  localparam logic [DIGIT_W-1:0] LETTER_BASE = 4'd10;

  typedef struct packed {
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_dec;
    logic               is_hex;
    logic               is_l;
    logic               is_u;
    logic               is_x;
    logic               is_b;
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               bad_digit;
  } result_t;

endpackage

// ===== src/integer_literal_parser.sv =====
// Top level of the integer literal parser: input register, APB register,
// classifier, parse core and result register.
// Depends on ilp_pkg, ilp_char_class, ilp_parse_core and the assertion header.
//
// Usage: one character of a C-style integer literal per input word on the
// in_valid/in_ready channel (char_code, last). The word with last set ends
// the literal; one result word (value, bad_digit) follows on the
// out_valid/out_ready channel. Words without last produce no result.
// Flow: a character sits in the input register and is parsed there;
// out_valid rises and the result register loads as a last word leaves the
// input register, which a pending result can delay (see Stall).
// Throughput: one character per cycle while in_ready is high, set by the
// shift-add of the accumulator in the parse core.
// Stall: while a result waits on out_ready, further characters without last
// keep flowing; a following last word is held in the input register and
// in_ready drops until the result is taken.
// Reset (rst, synchronous): clears the parse state and both valid flags and
// sets long_is_64_bit to 1; pready is tied high. The APB port (register 0
// at address 0) must be written only while idle, not enforced by the block.
`include "integer_literal_parser_assert.svh"

module integer_literal_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ilp_pkg::CHAR_W-1:0]   char_code,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ilp_pkg::VALUE_W-1:0]  value,
  output logic                         bad_digit,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ilp_pkg::ADDR_W-1:0]   paddr,
  input  logic [ilp_pkg::DATA_W-1:0]   pwdata,
  output logic [ilp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ilp_pkg::*;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              step;
  logic              accept;
  logic              long_is_64_bit;
  char_class_t       cls;
  result_t           res;

  assign pready   = 1'b1;
  assign prdata   = (paddr[ADDR_W-1] == REG_LONG_IS_64_BIT)
                    ? {{(DATA_W-1){1'b0}}, long_is_64_bit} : '0;
  assign step     = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || step;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_is_64_bit <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1] == REG_LONG_IS_64_BIT)) begin
      long_is_64_bit <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_char <= char_code;
      s1_last <= last;
    end
  end

  ilp_char_class u_class (
    .ch  (s1_char),
    .cls (cls)
  );

  ilp_parse_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .step_last      (s1_last),
    .cls            (cls),
    .long_is_64_bit (long_is_64_bit),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step && s1_last) begin
      value     <= res.value;
      bad_digit <= res.bad_digit;
    end
  end

  `ILP_ASSERT_NEXT(a_last_held, s1_valid && s1_last && out_valid && !out_ready,
                   s1_valid && s1_last, "last word dropped while result stalled")
  `ILP_ASSERT_SAME(a_no_overwrite, step && s1_last && out_valid, out_ready,
                   "result overwritten before it was taken")
  `ILP_ASSERT_NEXT(a_result_from_last, step && !s1_last && !(out_valid && !out_ready),
                   !out_valid, "result produced by a word without last")

endmodule

// ===== src/ilp_char_class.sv =====
// Character classifier: flags and digit value for one character.
// Depends on ilp_pkg.
module ilp_char_class (
  input  logic [ilp_pkg::CHAR_W-1:0] ch,
  output ilp_pkg::char_class_t       cls
);
  import ilp_pkg::*;

  logic [CHAR_W-1:0] up;
  logic              is_letter;
  logic [CHAR_W-1:0] dec_off;
  logic [CHAR_W-1:0] let_off;

  always_comb begin
    is_letter = (ch >= 8'h61) && (ch <= 8'h7A);
    up        = is_letter ? (ch & ~CASE_BIT) : ch;
    dec_off   = ch - CH_ZERO;
    let_off   = up - CH_UP_A;

    cls.is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    cls.is_plus  = (ch == CH_PLUS);
    cls.is_minus = (ch == CH_MINUS);
    cls.is_zero  = (ch == CH_ZERO);
    cls.is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls.is_hex   = cls.is_dec || ((up >= CH_UP_A) && (up <= CH_UP_F));
    cls.is_l     = (up == CH_UP_L);
    cls.is_u     = (up == CH_UP_U);
    cls.is_x     = (up == CH_UP_X);
    cls.is_b     = (up == CH_UP_B);
    cls.digit    = cls.is_dec ? dec_off[DIGIT_W-1:0]
                              : LETTER_BASE + let_off[DIGIT_W-1:0];
  end

endmodule

// ===== src/ilp_parse_core.sv =====
// Parse state and per-character update; yields the result for the last word.
// Depends on ilp_pkg and integer_literal_parser_assert.svh.
`include "integer_literal_parser_assert.svh"

module ilp_parse_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 step_last,
  input  ilp_pkg::char_class_t cls,
  input  logic                 long_is_64_bit,
  output ilp_pkg::result_t     res
);
  import ilp_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP, PH_SIGNED, PH_DEC, PH_SUFFIX, PH_ZERO, PH_PREFIX, PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC, RADIX_OCT, RADIX_HEX, RADIX_BIN
  } radix_t;

  phase_t             phase, phase_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic               is_negative, is_negative_next;
  radix_t             radix_mode, radix_mode_next;
  logic [1:0]         long_suffix_count, long_suffix_count_next;
  logic               unsigned_seen, unsigned_seen_next;
  logic               error_seen, error_seen_next;

  logic [VALUE_W-1:0] term;
  logic [VALUE_W-1:0] dec_sum;
  logic [VALUE_W-1:0] pre_shift;
  logic [VALUE_W-1:0] pre_sum;
  logic [VALUE_W-1:0] cin;
  logic [DIGIT_W:0]   limit;
  logic               narrow;
  logic [31:0]        low_word;

  // value kept with its sign applied: sign always precedes digits
  always_comb begin
    term = {{(VALUE_W-DIGIT_W){1'b0}}, cls.digit};
    if (is_negative) begin
      term = ~term;
    end
    cin     = {{(VALUE_W-1){1'b0}}, is_negative};
    dec_sum = (accumulator << 3) + (accumulator << 1) + term + cin;
    case (radix_mode)
      RADIX_HEX: begin
        pre_shift = accumulator << 4;
        limit     = 5'd16;
      end
      RADIX_BIN: begin
        pre_shift = accumulator << 1;
        limit     = 5'd2;
      end
      default: begin
        pre_shift = accumulator << 3;
        limit     = 5'd8;
      end
    endcase
    pre_sum = pre_shift + term + cin;
  end

  always_comb begin
    phase_next             = phase;
    accumulator_next       = accumulator;
    is_negative_next       = is_negative;
    radix_mode_next        = radix_mode;
    long_suffix_count_next = long_suffix_count;
    unsigned_seen_next     = unsigned_seen;
    error_seen_next        = error_seen;

    case (phase)
      PH_SKIP, PH_SIGNED, PH_DEC, PH_SUFFIX: begin
        if ((phase == PH_SKIP) && cls.is_space) begin
          phase_next = PH_SKIP;
        end else if ((phase == PH_SKIP) && (cls.is_plus || cls.is_minus)) begin
          is_negative_next = cls.is_minus;
          phase_next       = PH_SIGNED;
        end else if ((phase == PH_SKIP || phase == PH_SIGNED) && cls.is_zero) begin
          radix_mode_next = RADIX_OCT;
          phase_next      = PH_ZERO;
        end else if ((phase != PH_SUFFIX) && cls.is_dec) begin
          accumulator_next = dec_sum;
          phase_next       = PH_DEC;
        end else if (cls.is_l) begin
          if (long_suffix_count != 2'd2) begin
            long_suffix_count_next = long_suffix_count + 2'd1;
          end
          phase_next = PH_SUFFIX;
        end else if (cls.is_u) begin
          unsigned_seen_next = 1'b1;
          phase_next         = PH_SUFFIX;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_ZERO, PH_PREFIX: begin
        if ((phase == PH_ZERO) && cls.is_x) begin
          radix_mode_next = RADIX_HEX;
          phase_next      = PH_PREFIX;
        end else if ((phase == PH_ZERO) && cls.is_b) begin
          radix_mode_next = RADIX_BIN;
          phase_next      = PH_PREFIX;
        end else if (cls.is_hex) begin
          if ({1'b0, cls.digit} >= limit) begin
            error_seen_next = 1'b1;
          end
          accumulator_next = pre_sum;
          phase_next       = PH_PREFIX;
        end else begin
          phase_next = PH_STOP;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // narrowing applies to the decimal form only
    narrow = (radix_mode_next == RADIX_DEC) &&
             ((long_suffix_count_next == 2'd0) ||
              ((long_suffix_count_next == 2'd1) && !long_is_64_bit));
    low_word = accumulator_next[31:0];
    if (narrow) begin
      res.value = {{32{low_word[31] & ~unsigned_seen_next}}, low_word};
    end else begin
      res.value = accumulator_next;
    end
    res.bad_digit = error_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && step_last)) begin
      phase             <= PH_SKIP;
      accumulator       <= '0;
      is_negative       <= 1'b0;
      radix_mode        <= RADIX_DEC;
      long_suffix_count <= 2'd0;
      unsigned_seen     <= 1'b0;
      error_seen        <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      accumulator       <= accumulator_next;
      is_negative       <= is_negative_next;
      radix_mode        <= radix_mode_next;
      long_suffix_count <= long_suffix_count_next;
      unsigned_seen     <= unsigned_seen_next;
      error_seen        <= error_seen_next;
    end
  end

  `ILP_ASSERT_NEXT(a_clear_after_last, step && step_last,
                   phase == PH_SKIP && accumulator == '0 && !error_seen,
                   "parse state not cleared after last word")
  `ILP_ASSERT_SAME(a_dec_no_error, radix_mode == RADIX_DEC, !error_seen,
                   "digit error flagged in decimal form")
  `ILP_ASSERT_SAME(a_suffix_sat, 1'b1, long_suffix_count != 2'd3,
                   "long suffix count past saturation")

endmodule

// ===== dv/integer_literal_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for integer_literal_parser: character words in, parsed value out.
// Depends on ilp_pkg and the integer_literal_parser RTL; nothing else.
module integer_literal_parser_test;
  import ilp_pkg::*;

  typedef enum logic [2:0] {
    P_LEAD, P_SIGN, P_DEC, P_SUFFIX, P_ZERO, P_PREFIX, P_DONE
  } scan_phase_e;
  typedef enum logic [1:0] {R_DEC, R_OCT, R_HEX, R_BIN} radix_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              drain;
  } char_word_t;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CHAR    = 8'h0D;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CHAR_W-1:0]  char_code = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] value;
  logic               bad_digit;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  integer_literal_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .value(value), .bad_digit(bad_digit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser mirror
  scan_phase_e        scan_phase;
  radix_e             radix;
  logic [VALUE_W-1:0] accum;
  logic               neg;
  logic               uns_seen;
  logic               digit_err;
  logic [1:0]         l_count;
  logic               long64 = 1'b1;

  result_t            results_due[$];
  char_word_t         chars_to_send[$];
  logic [CHAR_W-1:0]  lit_buf[$];

  int failures = 0;
  int chars_sent = 0;
  int literals_sent = 0;
  int results_checked = 0;
  int bad_results = 0;
  int mode_writes = 0;

  function automatic void clear_scan();
    scan_phase = P_LEAD;
    radix      = R_DEC;
    accum      = '0;
    neg        = 1'b0;
    uns_seen   = 1'b0;
    digit_err  = 1'b0;
    l_count    = '0;
  endfunction

  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] ch);
    return (ch >= "a" && ch <= "z") ? (ch & ~CASE_BIT) : ch;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
    return ch == SPACE_CHAR || (ch >= TAB_CHAR && ch <= CR_CHAR);
  endfunction

  function automatic void decimal_char(input logic [CHAR_W-1:0] ch);
    if (scan_phase != P_SUFFIX && ch >= CH_ZERO && ch <= CH_NINE) begin
      accum = accum * 64'd10 + VALUE_W'(ch - CH_ZERO);
      scan_phase = P_DEC;
    end else if (upcase(ch) == CH_UP_L) begin
      if (l_count < 2'd2) l_count = l_count + 2'd1;
      scan_phase = P_SUFFIX;
    end else if (upcase(ch) == CH_UP_U) begin
      uns_seen = 1'b1;
      scan_phase = P_SUFFIX;
    end else begin
      scan_phase = P_DONE;
    end
  endfunction

  function automatic void prefixed_char(input logic [CHAR_W-1:0] ch);
    int d;
    int lim;
    int sh;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = ch - CH_ZERO;
    end else if (upcase(ch) >= CH_UP_A && upcase(ch) <= CH_UP_F) begin
      d = upcase(ch) - CH_UP_A + LETTER_BASE;
    end else begin
      scan_phase = P_DONE;
      return;
    end
    case (radix)
      R_HEX: begin lim = 16; sh = 4; end
      R_BIN: begin lim = 2;  sh = 1; end
      default: begin lim = 8; sh = 3; end
    endcase
    if (d >= lim) digit_err = 1'b1;
    accum = (accum << sh) + VALUE_W'(d);
    scan_phase = P_PREFIX;
  endfunction

  function automatic void scan_char(input logic [CHAR_W-1:0] ch, input logic is_last);
    logic [VALUE_W-1:0] v;
    result_t r;
    case (scan_phase)
      P_LEAD: begin
        if (!is_blank(ch)) begin
          if (ch == CH_PLUS || ch == CH_MINUS) begin
            neg = (ch == CH_MINUS);
            scan_phase = P_SIGN;
          end else if (ch == CH_ZERO) begin
            radix = R_OCT;
            scan_phase = P_ZERO;
          end else begin
            decimal_char(ch);
          end
        end
      end
      P_SIGN: begin
        if (ch == CH_ZERO) begin
          radix = R_OCT;
          scan_phase = P_ZERO;
        end else begin
          decimal_char(ch);
        end
      end
      P_DEC, P_SUFFIX: decimal_char(ch);
      P_ZERO: begin
        if (upcase(ch) == CH_UP_X) begin
          radix = R_HEX;
          scan_phase = P_PREFIX;
        end else if (upcase(ch) == CH_UP_B) begin
          radix = R_BIN;
          scan_phase = P_PREFIX;
        end else begin
          prefixed_char(ch);
        end
      end
      P_PREFIX: prefixed_char(ch);
      default: ;
    endcase
    if (is_last) begin
      v = neg ? ~accum + 64'd1 : accum;
      // decimal form is narrowed to the C type picked by the suffixes
      if (radix == R_DEC && (l_count == 0 || (l_count == 1 && !long64)))
        v = uns_seen ? {32'b0, v[31:0]} : {{32{v[31]}}, v[31:0]};
      r.value = v;
      r.bad_digit = digit_err;
      results_due = {results_due, r};
      clear_scan();
    end
  endfunction

  // stimulus building
  function automatic void put_char(input logic [CHAR_W-1:0] ch);
    lit_buf = {lit_buf, ch};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void end_literal(input logic drain);
    char_word_t w;
    for (int i = 0; i < lit_buf.size(); i++) begin
      w.code = lit_buf[i];
      w.last = (i == lit_buf.size() - 1);
      w.drain = drain && (i == 0);
      chars_to_send = {chars_to_send, w};
    end
    lit_buf.delete();
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? SPACE_CHAR : TAB_CHAR + CHAR_W'(r);
  endfunction

  function automatic void gen_literal();
    string hex_digits;
    string any_digits;
    string suffixes;
    int len;
    hex_digits = "0123456789abcdefABCDEF";
    any_digits = "0123456789abcdefABCDEFgG";
    suffixes   = "lLuU";
    if ($urandom_range(0, 9) == 0) begin
      // noise word burst
      repeat ($urandom_range(1, 6)) put_char(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_char(blank_char());
    case ($urandom_range(0, 3))
      0: put_char(CH_PLUS);
      1: put_char(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          put_char(CH_ZERO + CHAR_W'((i == 0) ? $urandom_range(1, 9)
                                              : $urandom_range(0, 9)));
        repeat ($urandom_range(0, 3))
          put_char(suffixes[$urandom_range(0, 3)]);
      end
      1: begin
        add_text($urandom_range(0, 1) ? "0x" : "0X");
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18) : $urandom_range(0, 8);
        repeat (len) put_char(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
      end
      2: begin
        add_text($urandom_range(0, 1) ? "0b" : "0B");
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 12);
        repeat (len)
          put_char(($urandom_range(0, 19) == 0)
              ? any_digits[$urandom_range(2, any_digits.len() - 3)]
              : CH_ZERO + CHAR_W'($urandom_range(0, 1)));
      end
      default: begin
        put_char(CH_ZERO);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 8);
        repeat (len)
          put_char(($urandom_range(0, 14) == 0)
              ? any_digits[$urandom_range(8, any_digits.len() - 1)]
              : CH_ZERO + CHAR_W'($urandom_range(0, 7)));
      end
    endcase
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) put_char(CHAR_W'($urandom_range(0, 255)));
  endfunction

  task automatic random_phase(input int n_chars);
    int added;
    int lits;
    added = 0;
    lits = 0;
    while (added < n_chars) begin
      gen_literal();
      added += lit_buf.size();
      end_literal(lits == 3 || $urandom_range(0, 24) == 0);
      lits++;
    end
  endtask

  task automatic wait_idle();
    while (chars_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_long_mode(input logic mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_LONG_IS_64_BIT, 2'b00});
    pwdata  <= DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    long64 = mode;
    mode_writes++;
  endtask

  // sender: bursts of words separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  char_word_t cur;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_char(char_code, last);
        chars_sent++;
        if (last) literals_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (chars_to_send.size() == 0 ||
                     (chars_to_send[0].drain && results_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur = chars_to_send.pop_front();
          in_valid  <= 1'b1;
          char_code <= cur.code;
          last      <= cur.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver and result check
  rx_mode_e rx_mode = RX_OPEN;
  int mode_cycles = 0;
  result_t due;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result word: value %h bad_digit %b",
                   $time, value, bad_digit);
          failures++;
        end else begin
          due = results_due.pop_front();
          if (value !== due.value) begin
            $display("%0t: value mismatch: expected %h, got %h", $time, due.value, value);
            failures++;
          end
          if (bad_digit !== due.bad_digit) begin
            $display("%0t: bad_digit mismatch: expected %b, got %b",
                     $time, due.bad_digit, bad_digit);
            failures++;
          end
          results_checked++;
          if (due.bad_digit) bad_results++;
        end
      end
      if (mode_cycles == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_cycles = $urandom_range(16, 96);
      end else begin
        mode_cycles--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (mode_cycles % 6 == 0);
      endcase
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_scan();
    // 64-bit long out of reset
    add_text(" \t-0x1Fg!");  end_literal(1'b0);
    add_text("0b102");       end_literal(1'b0);
    add_text("0789");        end_literal(1'b0);
    add_text("0");           end_literal(1'b0);
    add_text("0A");          end_literal(1'b0);
    add_text("0x");          end_literal(1'b0);
    add_text("+lU");         end_literal(1'b0);
    add_text("-1u");         end_literal(1'b0);
    add_text("7Ll");         end_literal(1'b0);
    add_text("\013\014\015\n-9L"); end_literal(1'b0);
    add_text("12 3");        end_literal(1'b0);
    add_text("- 5");         end_literal(1'b0);
    put_char(8'h00);         end_literal(1'b0);
    put_char(8'hFF);         end_literal(1'b0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    write_long_mode(1'b0);
    add_text("-1UL");        end_literal(1'b0);
    add_text("5L");          end_literal(1'b0);
    add_text("3000000000");  end_literal(1'b0);
    add_text("3000000000LL"); end_literal(1'b0);
    random_phase(190);
    wait_idle();

    write_long_mode(1'b1);
    random_phase(190);
    wait_idle();

    write_long_mode(1'b0);
    random_phase(180);
    wait_idle();

    $display("sent %0d words in %0d literals; %0d results checked, %0d with bad digits",
             chars_sent, literals_sent, results_checked, bad_results);
    $display("long width register written %0d times, both settings exercised", mode_writes);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
